### src/pfd_pkg.sv
// Package for the packet flow demultiplexer: slot, beat and result types,
// operation and result codes, and the delivery helper. No dependencies.
package pfd_pkg;

    localparam int SLOTS_DEFAULT = 16;
    localparam int NUM_TABLES    = 4;

    localparam logic [3:0] OP_CLASSIFY    = 4'd0;
    localparam logic [3:0] OP_WRITE_FIRST = 4'd1;
    localparam logic [3:0] OP_WRITE_LAST  = 4'd4;
    localparam logic [3:0] OP_CLEAR_FIRST = 4'd5;
    localparam logic [3:0] OP_CLEAR_LAST  = 4'd8;

    localparam logic [15:0] ETYPE_IPV4 = 16'h0800;
    localparam logic [15:0] ETYPE_ARP  = 16'h0806;
    localparam logic [7:0]  PROTO_ICMP = 8'd1;
    localparam logic [7:0]  PROTO_TCP  = 8'd6;
    localparam logic [7:0]  PROTO_UDP  = 8'd17;

    localparam logic [7:0] ETH_HDR_BYTES = 8'd14;
    localparam logic [7:0] UDP_HDR_BYTES = 8'd8;

    localparam logic [1:0] TBL_UDP    = 2'd0;
    localparam logic [1:0] TBL_ACTIVE = 2'd1;
    localparam logic [1:0] TBL_TWAIT  = 2'd2;
    localparam logic [1:0] TBL_LISTEN = 2'd3;

    localparam logic [1:0] ACT_DROP    = 2'd0;
    localparam logic [1:0] ACT_STACK   = 2'd1;
    localparam logic [1:0] ACT_SPLIT   = 2'd2;
    localparam logic [1:0] ACT_UPDATED = 2'd3;

    localparam logic [3:0] KIND_UNSUPPORTED = 4'd0;
    localparam logic [3:0] KIND_UDP_EXACT   = 4'd1;
    localparam logic [3:0] KIND_UDP_WILD    = 4'd2;
    localparam logic [3:0] KIND_TCP_ACTIVE  = 4'd3;
    localparam logic [3:0] KIND_TIME_WAIT   = 4'd4;
    localparam logic [3:0] KIND_LISTEN      = 4'd5;
    localparam logic [3:0] KIND_TCP_MISS    = 4'd6;
    localparam logic [3:0] KIND_ICMP        = 4'd7;
    localparam logic [3:0] KIND_ARP         = 4'd8;
    localparam logic [3:0] KIND_WRITE       = 4'd9;

    typedef struct packed {
        logic        valid;
        logic [31:0] local_addr;
        logic [31:0] remote_addr;
        logic [15:0] host_port;
        logic [15:0] peer_port;
        logic [15:0] session;
    } slot_t;

    typedef struct packed {
        logic [3:0]  op;
        logic [15:0] ethertype;
        logic [7:0]  ip_protocol;
        logic [3:0]  ip_header_words;
        logic [3:0]  tcp_header_words;
        logic [13:0] frame_length;
        logic [31:0] addr_a;
        logic [31:0] addr_b;
        logic [15:0] port_a;
        logic [15:0] port_b;
        logic [3:0]  entry_index;
        logic [15:0] session_in;
    } req_t;

    typedef struct packed {
        logic [1:0]  action;
        logic [3:0]  match_kind;
        logic [15:0] session_out;
        logic [7:0]  header_length;
        logic [13:0] payload_length;
    } res_t;

    // Session 0 sends the whole frame to the stack; otherwise split it.
    function automatic res_t deliver(logic [3:0] kind, logic [15:0] sess,
                                     logic [7:0] hdr, logic [13:0] flen);
        res_t r;
        r = '0;
        r.match_kind = kind;
        if (sess == 16'd0) begin
            r.action = ACT_STACK;
        end
        else begin
            r.action         = ACT_SPLIT;
            r.session_out    = sess;
            r.header_length  = hdr;
            r.payload_length = (flen > 14'(hdr)) ? (flen - 14'(hdr)) : 14'd0;
        end
        return r;
    endfunction

endpackage

### src/packet_flow_demux.sv
// Packet flow demultiplexer top level: lookup sequencer, slot memory, result register.
// Edits and non-table frames go from acceptance straight to the result; UDP frames scan
// the UDP table and TCP frames up to three tables, at one slot read per cycle.
// One beat is worked on at a time; the next is taken in the cycle after the result moves
// to the output register.
// After reset a clearing pass writes every slot before the first beat is taken.
// Depends on pfd_pkg, pfd_engine and pfd_slot_mem.
module packet_flow_demux #(
    parameter int SLOTS_PER_TABLE = pfd_pkg::SLOTS_DEFAULT
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [3:0]  op,
    input  logic [15:0] ethertype,
    input  logic [7:0]  ip_protocol,
    input  logic [3:0]  ip_header_words,
    input  logic [3:0]  tcp_header_words,
    input  logic [13:0] frame_length,
    input  logic [31:0] addr_a,
    input  logic [31:0] addr_b,
    input  logic [15:0] port_a,
    input  logic [15:0] port_b,
    input  logic [3:0]  entry_index,
    input  logic [15:0] session_in,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  action,
    output logic [3:0]  match_kind,
    output logic [15:0] session_out,
    output logic [7:0]  header_length,
    output logic [13:0] payload_length
);
    import pfd_pkg::*;

    localparam int DEPTH  = NUM_TABLES * SLOTS_PER_TABLE;
    localparam int ADDR_W = $clog2(DEPTH);

    req_t              req;
    logic              req_ready, res_valid, res_take;
    res_t              res;
    logic              rd_en, wr_en;
    logic [ADDR_W-1:0] rd_addr, wr_addr;
    slot_t             rd_data, wr_data;
    logic              out_valid_reg, out_valid_next;
    res_t              out_res_reg;

    assign req = '{op: op, ethertype: ethertype, ip_protocol: ip_protocol,
                   ip_header_words: ip_header_words, tcp_header_words: tcp_header_words,
                   frame_length: frame_length, addr_a: addr_a, addr_b: addr_b,
                   port_a: port_a, port_b: port_b, entry_index: entry_index,
                   session_in: session_in};

    pfd_engine #(.SLOTS(SLOTS_PER_TABLE)) u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (in_valid),
        .req       (req),
        .req_ready (req_ready),
        .res_valid (res_valid),
        .res       (res),
        .res_take  (res_take),
        .rd_en     (rd_en),
        .rd_addr   (rd_addr),
        .rd_data   (rd_data),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data)
    );

    pfd_slot_mem #(.DEPTH(DEPTH)) u_mem (
        .clk     (clk),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data)
    );

    assign in_stall       = !req_ready;
    assign res_take       = !out_valid_reg || !out_stall;
    assign out_valid_next = (res_valid && res_take) || (out_valid_reg && out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid && res_take)
        begin
            out_res_reg <= res;
        end
    end

    assign out_valid      = out_valid_reg;
    assign action         = out_res_reg.action;
    assign match_kind     = out_res_reg.match_kind;
    assign session_out    = out_res_reg.session_out;
    assign header_length  = out_res_reg.header_length;
    assign payload_length = out_res_reg.payload_length;

endmodule

### src/pfd_slot_mem.sv
// Slot memory of the demultiplexer: one write port, one registered read port.
// Depends on pfd_pkg for the slot type.
module pfd_slot_mem #(
    parameter int DEPTH = pfd_pkg::NUM_TABLES * pfd_pkg::SLOTS_DEFAULT,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  logic               clk,
    input  logic               rd_en,
    input  logic [ADDR_W-1:0]  rd_addr,
    output pfd_pkg::slot_t     rd_data,
    input  logic               wr_en,
    input  logic [ADDR_W-1:0]  wr_addr,
    input  pfd_pkg::slot_t     wr_data
);
    import pfd_pkg::*;

    slot_t mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

### src/pfd_engine.sv
// Lookup sequencer: clears the slot memory after reset, applies table edits
// and scans the tables one slot per cycle. Depends on pfd_pkg.
module pfd_engine #(
    parameter int SLOTS = pfd_pkg::SLOTS_DEFAULT,
    localparam int ADDR_W = $clog2(pfd_pkg::NUM_TABLES * SLOTS)
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    input  pfd_pkg::req_t      req,
    output logic               req_ready,
    output logic               res_valid,
    output pfd_pkg::res_t      res,
    input  logic               res_take,
    output logic               rd_en,
    output logic [ADDR_W-1:0]  rd_addr,
    input  pfd_pkg::slot_t     rd_data,
    output logic               wr_en,
    output logic [ADDR_W-1:0]  wr_addr,
    output pfd_pkg::slot_t     wr_data
);
    import pfd_pkg::*;

    localparam int CNT_W = $clog2(SLOTS + 1);
    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(NUM_TABLES * SLOTS - 1);

    typedef enum logic [4:0] {
        ST_CLEAR = 5'b00001,
        ST_IDLE  = 5'b00010,
        ST_SCAN  = 5'b00100,
        ST_WB    = 5'b01000,
        ST_DONE  = 5'b10000
    } state_t;

    state_t             state_reg, state_next;
    logic [ADDR_W-1:0]  addr_reg, addr_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [1:0]         tbl_reg, tbl_next;
    logic               chk_v_reg, chk_v_next;
    logic               chk_last_reg, chk_last_next;
    logic [ADDR_W-1:0]  chk_addr_reg, chk_addr_next;
    logic               wc_found_reg, wc_found_next;
    logic [ADDR_W-1:0]  wc_addr_reg, wc_addr_next;
    slot_t              wc_slot_reg, wc_slot_next;
    req_t               req_reg, req_next;
    logic [7:0]         hdr_reg, hdr_next;
    res_t               res_reg, res_next;

    logic port_ok, laddr_wc, raddr_wc, exact_wc, local_wc, strict_hit;
    logic hit_now, issue;
    slot_t wb_slot;

    function automatic logic [ADDR_W-1:0] table_base(logic [1:0] t);
        return ADDR_W'(t) * ADDR_W'(SLOTS);
    endfunction

    // Compare the slot read last cycle against the held frame.
    always_comb
    begin
        port_ok    = rd_data.valid && (rd_data.host_port == req_reg.port_b);
        laddr_wc   = (rd_data.local_addr == 32'd0) || (rd_data.local_addr == req_reg.addr_b);
        raddr_wc   = (rd_data.remote_addr == 32'd0)
                     || (rd_data.remote_addr == req_reg.addr_a);
        local_wc   = port_ok && laddr_wc;
        exact_wc   = local_wc && raddr_wc && (rd_data.peer_port == req_reg.port_a);
        strict_hit = port_ok && (rd_data.peer_port == req_reg.port_a)
                     && (rd_data.remote_addr == req_reg.addr_a)
                     && (rd_data.local_addr == req_reg.addr_b);
        case (tbl_reg)
            TBL_UDP:    hit_now = chk_v_reg && exact_wc;
            TBL_LISTEN: hit_now = chk_v_reg && local_wc;
            default:    hit_now = chk_v_reg && strict_hit;
        endcase
        issue = (state_reg == ST_SCAN) && (cnt_reg != CNT_W'(SLOTS)) && !hit_now;
    end

    always_comb
    begin
        state_next    = state_reg;
        addr_next     = addr_reg;
        cnt_next      = cnt_reg;
        tbl_next      = tbl_reg;
        chk_v_next    = 1'b0;
        chk_last_next = 1'b0;
        chk_addr_next = addr_reg;
        wc_found_next = wc_found_reg;
        wc_addr_next  = wc_addr_reg;
        wc_slot_next  = wc_slot_reg;
        req_next      = req_reg;
        hdr_next      = hdr_reg;
        res_next      = res_reg;
        rd_en         = 1'b0;
        rd_addr       = addr_reg;
        wr_en         = 1'b0;
        wr_addr       = addr_reg;
        wr_data       = '0;
        wb_slot       = wc_slot_reg;
        wb_slot.peer_port = req_reg.port_a;

        unique case (state_reg)
            ST_CLEAR:
            begin
                wr_en = 1'b1;
                if (addr_reg == LAST_ADDR)
                begin
                    addr_next  = '0;
                    state_next = ST_IDLE;
                end
                else
                begin
                    addr_next = addr_reg + 1'b1;
                end
            end
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    req_next      = req;
                    hdr_next      = ETH_HDR_BYTES + 8'({req.ip_header_words, 2'b00})
                                    + ((req.ip_protocol == PROTO_UDP) ? UDP_HDR_BYTES
                                       : 8'({req.tcp_header_words, 2'b00}));
                    cnt_next      = '0;
                    wc_found_next = 1'b0;
                    res_next      = '0;
                    state_next    = ST_DONE;
                    case (req.op) inside
                        [OP_WRITE_FIRST:OP_CLEAR_LAST]:
                        begin
                            res_next.action     = ACT_UPDATED;
                            res_next.match_kind = KIND_WRITE;
                            if ({28'd0, req.entry_index} < 32'(SLOTS))
                            begin
                                wr_en   = 1'b1;
                                wr_addr = table_base(2'(req.op - 4'd1))
                                          + ADDR_W'(req.entry_index);
                                if (req.op <= OP_WRITE_LAST)
                                begin
                                    wr_data.valid       = 1'b1;
                                    wr_data.remote_addr = req.addr_a;
                                    wr_data.local_addr  = req.addr_b;
                                    wr_data.peer_port   = req.port_a;
                                    wr_data.host_port   = req.port_b;
                                    wr_data.session     = req.session_in;
                                end
                            end
                        end
                        OP_CLASSIFY:
                        begin
                            if (req.ethertype == ETYPE_ARP)
                            begin
                                res_next.action     = ACT_STACK;
                                res_next.match_kind = KIND_ARP;
                            end
                            else if (req.ethertype == ETYPE_IPV4)
                            begin
                                if (req.ip_protocol == PROTO_ICMP)
                                begin
                                    res_next.action     = ACT_STACK;
                                    res_next.match_kind = KIND_ICMP;
                                end
                                else if (req.ip_protocol == PROTO_UDP)
                                begin
                                    tbl_next   = TBL_UDP;
                                    addr_next  = table_base(TBL_UDP);
                                    state_next = ST_SCAN;
                                end
                                else if (req.ip_protocol == PROTO_TCP)
                                begin
                                    tbl_next   = TBL_ACTIVE;
                                    addr_next  = table_base(TBL_ACTIVE);
                                    state_next = ST_SCAN;
                                end
                            end
                        end
                        default:
                        begin
                            res_next = '0;
                        end
                    endcase
                end
            end
            ST_SCAN:
            begin
                if (issue)
                begin
                    rd_en         = 1'b1;
                    addr_next     = addr_reg + 1'b1;
                    cnt_next      = cnt_reg + 1'b1;
                    chk_v_next    = 1'b1;
                    chk_last_next = (cnt_reg == CNT_W'(SLOTS - 1));
                end
                if (hit_now)
                begin
                    state_next = ST_DONE;
                    res_next   = '0;
                    case (tbl_reg)
                        TBL_UDP:
                            res_next = deliver(KIND_UDP_EXACT, rd_data.session, hdr_reg,
                                               req_reg.frame_length);
                        TBL_ACTIVE:
                            res_next = deliver(KIND_TCP_ACTIVE, rd_data.session, hdr_reg,
                                               req_reg.frame_length);
                        TBL_TWAIT:
                            res_next.match_kind = KIND_TIME_WAIT;
                        default:
                            res_next = deliver(KIND_LISTEN, rd_data.session, hdr_reg,
                                               req_reg.frame_length);
                    endcase
                end
                else
                begin
                    // The first host port and local address hit is kept in case no exact hit follows.
                    if (tbl_reg == TBL_UDP && chk_v_reg && local_wc && !wc_found_reg)
                    begin
                        wc_found_next = 1'b1;
                        wc_addr_next  = chk_addr_reg;
                        wc_slot_next  = rd_data;
                    end
                    if (chk_v_reg && chk_last_reg)
                    begin
                        cnt_next = '0;
                        case (tbl_reg)
                            TBL_UDP:
                                state_next = ST_WB;
                            TBL_LISTEN:
                            begin
                                res_next   = deliver(KIND_TCP_MISS, 16'd0, hdr_reg,
                                                     req_reg.frame_length);
                                state_next = ST_DONE;
                            end
                            default:
                            begin
                                tbl_next  = tbl_reg + 2'd1;
                                addr_next = table_base(tbl_reg + 2'd1);
                            end
                        endcase
                    end
                end
            end
            ST_WB:
            begin
                res_next = '0;
                if (wc_found_reg)
                begin
                    wr_en    = 1'b1;
                    wr_addr  = wc_addr_reg;
                    wr_data  = wb_slot;
                    res_next = deliver(KIND_UDP_WILD, wc_slot_reg.session, hdr_reg,
                                       req_reg.frame_length);
                end
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (res_take)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_CLEAR;
            addr_reg     <= '0;
            cnt_reg      <= '0;
            tbl_reg      <= TBL_UDP;
            chk_v_reg    <= 1'b0;
            chk_last_reg <= 1'b0;
            wc_found_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            addr_reg     <= addr_next;
            cnt_reg      <= cnt_next;
            tbl_reg      <= tbl_next;
            chk_v_reg    <= chk_v_next;
            chk_last_reg <= chk_last_next;
            wc_found_reg <= wc_found_next;
        end
    end

    always_ff @(posedge clk)
    begin
        chk_addr_reg <= chk_addr_next;
        wc_addr_reg  <= wc_addr_next;
        wc_slot_reg  <= wc_slot_next;
        req_reg      <= req_next;
        hdr_reg      <= hdr_next;
        res_reg      <= res_next;
    end

    assign req_ready = (state_reg == ST_IDLE);
    assign res_valid = (state_reg == ST_DONE);
    assign res       = res_reg;

endmodule

### src/pfd_checker.sv
// Port-level checks for the packet flow demultiplexer, bound to the top level.
// Depends on pfd_pkg and packet_flow_demux.
module pfd_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_stall,
    input logic [1:0]  action,
    input logic [3:0]  match_kind,
    input logic [15:0] session_out,
    input logic [7:0]  header_length,
    input logic [13:0] payload_length
);
    import pfd_pkg::*;

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result beat dropped while stalled");

    a_split_session: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && action == ACT_SPLIT |-> session_out != 16'd0)
        else $error("split delivery to session 0");

    a_nosplit_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && action != ACT_SPLIT |->
            session_out == 16'd0 && header_length == 8'd0 && payload_length == 14'd0)
        else $error("lengths or session set without split delivery");

    a_update_kind: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (action == ACT_UPDATED) |-> match_kind == KIND_WRITE)
        else $error("table update with wrong match kind");

endmodule

bind packet_flow_demux pfd_checker u_pfd_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .action         (action),
    .match_kind     (match_kind),
    .session_out    (session_out),
    .header_length  (header_length),
    .payload_length (payload_length)
);

### verif/packet_flow_demux_check.sv
// Flow demultiplexer checker: watches the request and result channels, runs a
// table predictor on every accepted beat and compares results. Depends on pfd_pkg.
module packet_flow_demux_check (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_stall,
    input  logic [3:0]  op,
    input  logic [15:0] ethertype,
    input  logic [7:0]  ip_protocol,
    input  logic [3:0]  ip_header_words,
    input  logic [3:0]  tcp_header_words,
    input  logic [13:0] frame_length,
    input  logic [31:0] addr_a,
    input  logic [31:0] addr_b,
    input  logic [15:0] port_a,
    input  logic [15:0] port_b,
    input  logic [3:0]  entry_index,
    input  logic [15:0] session_in,
    input  logic        out_valid,
    input  logic        out_stall,
    input  logic [1:0]  action,
    input  logic [3:0]  match_kind,
    input  logic [15:0] session_out,
    input  logic [7:0]  header_length,
    input  logic [13:0] payload_length,
    output int          errors,
    output int          pending
);
    timeunit 1ns;
    timeprecision 1ps;
    import pfd_pkg::*;

    localparam int SLOTS = SLOTS_DEFAULT;

    typedef enum int { FIND_EXACT_WILD, FIND_LOCAL, FIND_EXACT_STRICT } find_mode_t;

    slot_t flow_slots [NUM_TABLES*SLOTS];
    res_t  expected_results [$];

    function automatic bit addr_matches(logic [31:0] stored, logic [31:0] seen, bit wild);
        return (wild && stored == 32'd0) || stored == seen;
    endfunction

    function automatic int find_flow(int tbl, find_mode_t mode, req_t r);
        int s;
        bit hit;
        for (int i = 0; i < SLOTS; i++)
        begin
            s = tbl*SLOTS + i;
            if (!flow_slots[s].valid || flow_slots[s].host_port != r.port_b)
                continue;
            if (mode == FIND_LOCAL)
                hit = addr_matches(flow_slots[s].local_addr, r.addr_b, 1);
            else
                hit = flow_slots[s].peer_port == r.port_a
                    && addr_matches(flow_slots[s].remote_addr, r.addr_a,
                                    mode == FIND_EXACT_WILD)
                    && addr_matches(flow_slots[s].local_addr, r.addr_b,
                                    mode == FIND_EXACT_WILD);
            if (hit)
                return s;
        end
        return -1;
    endfunction

    function automatic res_t steer(logic [3:0] kind, logic [15:0] sess,
                                   int hdr, logic [13:0] flen);
        res_t r;
        r = '0;
        r.match_kind = kind;
        if (sess == 0)
        begin
            r.action = ACT_STACK;
        end
        else
        begin
            r.action = ACT_SPLIT;
            r.session_out = sess;
            r.header_length = hdr[7:0];
            r.payload_length = (flen > hdr) ? 14'(flen - hdr) : 14'd0;
        end
        return r;
    endfunction

    function automatic res_t classify_beat(req_t r);
        res_t res;
        int s, g, hdr;
        res = '0;
        if (r.op >= OP_WRITE_FIRST && r.op <= OP_CLEAR_LAST)
        begin
            res.action = ACT_UPDATED;
            res.match_kind = KIND_WRITE;
            if (r.entry_index < SLOTS)
            begin
                g = ((r.op - 1) % 4)*SLOTS + r.entry_index;
                if (r.op <= OP_WRITE_LAST)
                    flow_slots[g] = '{1'b1, r.addr_b, r.addr_a, r.port_b, r.port_a,
                                      r.session_in};
                else
                    flow_slots[g].valid = 1'b0;
            end
            return res;
        end
        if (r.op != OP_CLASSIFY)
            return res;
        if (r.ethertype == ETYPE_ARP)
        begin
            res.action = ACT_STACK;
            res.match_kind = KIND_ARP;
            return res;
        end
        if (r.ethertype != ETYPE_IPV4)
            return res;
        if (r.ip_protocol == PROTO_ICMP)
        begin
            res.action = ACT_STACK;
            res.match_kind = KIND_ICMP;
        end
        else if (r.ip_protocol == PROTO_UDP)
        begin
            hdr = 14 + 4*r.ip_header_words + 8;
            s = find_flow(TBL_UDP, FIND_EXACT_WILD, r);
            if (s >= 0)
            begin
                res = steer(KIND_UDP_EXACT, flow_slots[s].session, hdr, r.frame_length);
            end
            else
            begin
                s = find_flow(TBL_UDP, FIND_LOCAL, r);
                if (s >= 0)
                begin
                    flow_slots[s].peer_port = r.port_a;
                    res = steer(KIND_UDP_WILD, flow_slots[s].session, hdr,
                                r.frame_length);
                end
            end
        end
        else if (r.ip_protocol == PROTO_TCP)
        begin
            hdr = 14 + 4*r.ip_header_words + 4*r.tcp_header_words;
            s = find_flow(TBL_ACTIVE, FIND_EXACT_STRICT, r);
            if (s >= 0)
            begin
                res = steer(KIND_TCP_ACTIVE, flow_slots[s].session, hdr, r.frame_length);
            end
            else if (find_flow(TBL_TWAIT, FIND_EXACT_STRICT, r) >= 0)
            begin
                res.match_kind = KIND_TIME_WAIT;
            end
            else
            begin
                s = find_flow(TBL_LISTEN, FIND_LOCAL, r);
                if (s >= 0)
                    res = steer(KIND_LISTEN, flow_slots[s].session, hdr, r.frame_length);
                else
                    res = steer(KIND_TCP_MISS, 16'd0, hdr, r.frame_length);
            end
        end
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        res_t want, got;
        if (!rst_n)
        begin
            foreach (flow_slots[i])
                flow_slots[i] = '0;
            expected_results.delete();
            errors = 0;
            pending = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                got = '{action, match_kind, session_out, header_length, payload_length};
                if (expected_results.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected result %h", $time, got);
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (want.action != got.action || want.match_kind != got.match_kind
                        || want.session_out != got.session_out
                        || want.header_length != got.header_length
                        || want.payload_length != got.payload_length)
                    begin
                        errors++;
                        $display("%0t: mismatch expected act=%0d kind=%0d sess=%h hdr=%0d",
                                 $time, want.action, want.match_kind, want.session_out,
                                 want.header_length, " pay=%0d", want.payload_length,
                                 ", actual act=%0d kind=%0d sess=%h hdr=%0d pay=%0d",
                                 got.action, got.match_kind, got.session_out,
                                 got.header_length, got.payload_length);
                    end
                end
            end
            if (in_valid && !in_stall)
                expected_results.push_back(classify_beat('{op, ethertype, ip_protocol,
                    ip_header_words, tcp_header_words, frame_length, addr_a, addr_b,
                    port_a, port_b, entry_index, session_in}));
            pending = expected_results.size();
        end
    end

endmodule

### verif/packet_flow_demux_test.sv
// Flow demultiplexer testbench top: clock, reset, request stimulus, result
// stalls and verdict. Depends on pfd_pkg, packet_flow_demux and its checker.
module packet_flow_demux_test;
    timeunit 1ns;
    timeprecision 1ps;
    import pfd_pkg::*;

    localparam int IDLE_LIMIT = 5000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic out_stall = 1'b0;
    logic in_stall, out_valid;
    req_t req = '0;
    logic [1:0] action;
    logic [3:0] match_kind;
    logic [15:0] session_out;
    logic [7:0] header_length;
    logic [13:0] payload_length;
    int errors, pending, quiet_cycles;
    bit calm = 0;

    // A small pool of addresses and ports so that frames hit the tables often.
    logic [31:0] addr_pool [4] = '{32'h0a000001, 32'h0a000002, 32'hffffffff, 32'h0};
    logic [15:0] port_pool [4] = '{16'd80, 16'd53, 16'hffff, 16'd0};

    always #5 clk = ~clk;

    packet_flow_demux dut (
        .clk, .rst_n, .in_valid, .in_stall,
        .op(req.op), .ethertype(req.ethertype), .ip_protocol(req.ip_protocol),
        .ip_header_words(req.ip_header_words), .tcp_header_words(req.tcp_header_words),
        .frame_length(req.frame_length), .addr_a(req.addr_a), .addr_b(req.addr_b),
        .port_a(req.port_a), .port_b(req.port_b), .entry_index(req.entry_index),
        .session_in(req.session_in), .out_valid, .out_stall, .action, .match_kind,
        .session_out, .header_length, .payload_length
    );

    packet_flow_demux_check checker_i (
        .clk, .rst_n, .in_valid, .in_stall,
        .op(req.op), .ethertype(req.ethertype), .ip_protocol(req.ip_protocol),
        .ip_header_words(req.ip_header_words), .tcp_header_words(req.tcp_header_words),
        .frame_length(req.frame_length), .addr_a(req.addr_a), .addr_b(req.addr_b),
        .port_a(req.port_a), .port_b(req.port_b), .entry_index(req.entry_index),
        .session_in(req.session_in), .out_valid, .out_stall, .action, .match_kind,
        .session_out, .header_length, .payload_length, .errors, .pending
    );

    // Called at a falling edge; returns at the falling edge after the beat is taken,
    // with valid still high so that the next beat can follow without a gap.
    task automatic send_beat(req_t r);
        if (!calm && $urandom_range(0, 5) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(negedge clk);
        end
        req <= r;
        in_valid <= 1'b1;
        // Stall only moves at the rising edge, so it is read in the low half.
        while (in_stall)
            @(negedge clk);
        @(posedge clk);
        @(negedge clk);
    endtask

    // Writes mostly land in the pool values; frames mostly reuse them.
    function automatic req_t make_flow_beat();
        req_t r;
        r = $bits(req_t)'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom});
        r.addr_a = ($urandom_range(0, 3) != 0) ? addr_pool[$urandom_range(0, 3)] : r.addr_a;
        r.addr_b = ($urandom_range(0, 3) != 0) ? addr_pool[$urandom_range(0, 3)] : r.addr_b;
        r.port_a = ($urandom_range(0, 3) != 0) ? port_pool[$urandom_range(0, 3)] : r.port_a;
        r.port_b = ($urandom_range(0, 3) != 0) ? port_pool[$urandom_range(0, 3)] : r.port_b;
        if ($urandom_range(0, 2) == 0)
            r.session_in = 16'd0;
        case ($urandom_range(0, 19))
            0, 1, 2, 3: r.op = 4'($urandom_range(1, 4));
            4:          r.op = 4'($urandom_range(5, 8));
            5:          r.op = 4'($urandom_range(9, 15));
            default:    r.op = OP_CLASSIFY;
        endcase
        if (r.op >= OP_WRITE_FIRST && r.op <= OP_CLEAR_LAST && $urandom_range(0, 9) != 0)
            r.entry_index = 4'($urandom_range(0, 3));
        if (r.op == OP_CLASSIFY)
        begin
            case ($urandom_range(0, 9))
                0:       r.ethertype = ETYPE_ARP;
                1:       ;
                default: r.ethertype = ETYPE_IPV4;
            endcase
            case ($urandom_range(0, 9))
                0:       r.ip_protocol = PROTO_ICMP;
                1:       ;
                2, 3, 4, 5: r.ip_protocol = PROTO_TCP;
                default: r.ip_protocol = PROTO_UDP;
            endcase
            if ($urandom_range(0, 1))
                r.frame_length = 14'($urandom_range(0, 1600));
        end
        return r;
    endfunction

    function automatic req_t directed_beat(logic [3:0] op, logic [15:0] et, logic [7:0] pr,
                                           logic [31:0] sa, logic [31:0] da,
                                           logic [15:0] sp, logic [15:0] dp,
                                           logic [3:0] idx, logic [15:0] sess);
        return '{op, et, pr, 4'd5, 4'd5, 14'd100, sa, da, sp, dp, idx, sess};
    endfunction

    initial
    begin
        req_t r;
        repeat (6) @(negedge clk);
        rst_n <= 1'b1;

        // Table setup, then frames hitting each lookup path.
        send_beat(directed_beat(OP_WRITE_FIRST, 0, 0, 32'h0, 32'h0a000001, 16'd7, 16'd53,
                                4'd0, 16'h1234));
        send_beat(directed_beat(OP_WRITE_FIRST, 0, 0, 32'h0a000002, 32'h0, 16'd9, 16'd80,
                                4'd15, 0));
        send_beat(directed_beat(OP_WRITE_FIRST + 4'(TBL_ACTIVE), 0, 0, 32'h1, 32'h2,
                                16'd3, 16'd4, 4'd3, 16'hffff));
        send_beat(directed_beat(OP_WRITE_FIRST + 4'(TBL_TWAIT), 0, 0, 32'h5, 32'h6,
                                16'd7, 16'd8, 4'd0, 16'd1));
        send_beat(directed_beat(OP_WRITE_LAST, 0, 0, 32'h9, 32'h0, 16'd1, 16'd22, 4'd2,
                                16'd77));
        send_beat(directed_beat(OP_WRITE_LAST, 0, 0, 32'h9, 32'h0, 16'd1, 16'd22, 4'd1,
                                16'd0));
        send_beat(directed_beat(OP_CLASSIFY, ETYPE_IPV4, PROTO_UDP, 32'h8, 32'h0a000001,
                                16'd7, 16'd53, 0, 0));
        send_beat(directed_beat(OP_CLASSIFY, ETYPE_IPV4, PROTO_UDP, 32'h8, 32'h0a000001,
                                16'd99, 16'd53, 0, 0));
        send_beat(directed_beat(OP_CLASSIFY, ETYPE_IPV4, PROTO_UDP, 32'h8, 32'h0a000001,
                                16'd99, 16'd53, 0, 0));
        send_beat(directed_beat(OP_CLASSIFY, ETYPE_IPV4, PROTO_TCP, 32'h1, 32'h2,
                                16'd3, 16'd4, 0, 0));
        send_beat(directed_beat(OP_CLASSIFY, ETYPE_IPV4, PROTO_TCP, 32'h5, 32'h6,
                                16'd7, 16'd8, 0, 0));
        send_beat(directed_beat(OP_CLASSIFY, ETYPE_IPV4, PROTO_TCP, 32'h55, 32'h66,
                                16'd2, 16'd22, 0, 0));
        send_beat(directed_beat(OP_CLASSIFY, ETYPE_IPV4, PROTO_TCP, 32'h55, 32'h66,
                                16'd2, 16'd23, 0, 0));
        send_beat(directed_beat(OP_CLASSIFY, ETYPE_ARP, 0, 0, 0, 0, 0, 0, 0));
        send_beat(directed_beat(OP_CLASSIFY, ETYPE_IPV4, PROTO_ICMP, 0, 0, 0, 0, 0, 0));
        send_beat(directed_beat(OP_CLASSIFY, 16'hffff, PROTO_UDP, 0, 0, 0, 0, 0, 0));
        send_beat(directed_beat(OP_CLASSIFY, ETYPE_IPV4, 8'hff, 0, 0, 0, 0, 0, 0));
        send_beat(directed_beat(4'd15, 0, 0, 0, 0, 0, 0, 0, 0));
        send_beat(directed_beat(4'd9, 0, 0, 0, 0, 0, 0, 0, 0));
        send_beat(directed_beat(OP_CLEAR_FIRST + 4'(TBL_ACTIVE), 0, 0, 0, 0, 0, 0, 4'd3,
                                0));
        // Extreme header words against the active-table miss path, then an empty frame against an active hit.
        r = directed_beat(OP_CLASSIFY, ETYPE_IPV4, PROTO_TCP, 32'h1, 32'h2, 16'd3, 16'd4,
                          0, 0);
        r.ip_header_words = 4'hf;
        r.tcp_header_words = 4'hf;
        r.frame_length = 14'h3fff;
        send_beat(r);
        send_beat(directed_beat(OP_WRITE_FIRST + 4'(TBL_ACTIVE), 0, 0, 32'h1, 32'h2,
                                16'd3, 16'd4, 4'd3, 16'hffff));
        r.frame_length = 14'd0;
        send_beat(r);
        r.ip_protocol = PROTO_UDP;
        r.addr_b = 32'h0a000001;
        r.port_b = 16'd53;
        r.ip_header_words = 4'd0;
        send_beat(r);

        // The sender holds off until the block has drained once.
        in_valid <= 1'b0;
        wait (pending == 0);
        @(negedge clk);

        for (int n = 0; n < 1250; n++)
        begin
            if (n == 1100)
                calm = 1;
            send_beat(make_flow_beat());
        end
        in_valid <= 1'b0;
    end

    // Result stalls in random bursts, none near the end.
    initial
    begin
        out_stall <= 1'b0;
        forever
        begin
            @(negedge clk);
            if (!calm && $urandom_range(0, 7) == 0)
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 12)) @(negedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    initial
    begin
        quiet_cycles = 0;
        wait (calm);
        forever
        begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (!in_valid && pending == 0 && quiet_cycles > 60)
            begin
                if (errors == 0)
                    $display("All tests passed");
                else
                    $display("Some tests failed");
                $finish;
            end
        end
    end

    initial
    begin
        int idle;
        idle = 0;
        forever
        begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                idle = 0;
            else
                idle++;
            if (idle >= IDLE_LIMIT)
            begin
                $display("Some tests failed");
                $finish;
            end
        end
    end

endmodule

### filelist.f
src/pfd_pkg.sv
src/pfd_slot_mem.sv
src/pfd_engine.sv
src/packet_flow_demux.sv
src/pfd_checker.sv
verif/packet_flow_demux_check.sv
verif/packet_flow_demux_test.sv
